// ===== design/assert_macros.svh =====
// Assertion macros shared by the paginator RTL.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/spte_pkg.sv =====
// Types, character codes and the result renderer of the text escape paginator.
// No dependencies; used by all paginator modules.
package spte_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_flag;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        char_valid;
		logic        page_mark;
		logic [23:0] line_number;
		logic [15:0] page_total;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_CHAR  = 3'd0,
		OP_CARET = 3'd1,
		OP_DEL   = 3'd2,
		OP_NL    = 3'd3,
		OP_TAB   = 3'd4,
		OP_MARK  = 3'd5
	} op_t;

	// One classified input byte: what the back end has to expand.
	typedef struct packed {
		op_t         op;
		logic        high;
		logic [6:0]  ch;
		logic        nl_first;
		logic [3:0]  count;
		logic [23:0] line_number;
		logic [15:0] page_total;
	} cmd_t;

	localparam int CMD_QDEPTH = 4;

	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] HIGH_BIT = 8'h80;

	// Result number idx of command c.
	function automatic out_item_t render(cmd_t c, logic [2:0] idx);
		out_item_t  r;
		logic [2:0] j;
		r = '0;
		j = c.high ? idx - 3'd2 : idx;
		r.char_valid = 1'b1;
		if (c.high && idx == 3'd0) begin
			r.out_char = CH_M;
		end else if (c.high && idx == 3'd1) begin
			r.out_char = CH_DASH;
		end else begin
			unique case (c.op)
				OP_CHAR:  r.out_char = {1'b0, c.ch};
				OP_CARET: r.out_char = (j == 3'd0) ? CH_CARET : {1'b0, c.ch + 7'h20};
				OP_DEL: begin
					unique case (j)
						3'd0:    r.out_char = CH_D;
						3'd1:    r.out_char = CH_E;
						default: r.out_char = CH_L;
					endcase
				end
				OP_TAB:   r.out_char = CH_SPACE;
				OP_NL:    r.out_char = CH_NL;
				OP_MARK: begin
					if (c.nl_first && idx == 3'd0) begin
						r.out_char = CH_NL;
					end else begin
						r.char_valid  = 1'b0;
						r.page_mark   = 1'b1;
						r.line_number = c.line_number;
						r.page_total  = c.page_total;
					end
				end
				default:  r.out_char = '0;
			endcase
		end
		r.last = (({1'b0, idx} + 4'd1) == c.count);
		return r;
	endfunction

endpackage

// ===== design/spte_front.sv =====
// Front end: accepts input bytes, tracks column, line and page state, and emits
// one classified command per byte, none for a carriage return. Depends on spte_pkg.
`include "assert_macros.svh"

module spte_front #(
	parameter int TAB_STOP  = 8,
	parameter int LINE_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  spte_pkg::in_item_t item,
	input  logic               q_full,
	output logic               q_wr,
	output spte_pkg::cmd_t     q_cmd
);

	localparam int CW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int SW = CW + 3;

	logic [CW-1:0]        phase_q, phase_d;
	logic                 open_q, open_d;
	logic [LINE_BITS-1:0] line_q, line_d, line_closed;
	logic [15:0]          page_q, page_d;
	logic                 accept, has_cmd;
	spte_pkg::cmd_t       cmd;
	logic [6:0]           low7;
	logic [SW-1:0]        sum, tab_n;
	logic [31:0]          line_ext;

	assign accept = push && !q_full;
	assign low7   = item.byte_in[6:0];
	assign tab_n  = SW'(TAB_STOP) - SW'(phase_q);

	// A form feed or end marker closes an open line first.
	assign line_closed = open_q ? line_q + 1'b1 : line_q;
	assign line_ext    = 32'(line_closed);

	always_comb begin
		cmd         = '0;
		has_cmd     = 1'b1;
		phase_d     = phase_q;
		open_d      = open_q;
		line_d      = line_q;
		page_d      = page_q;
		sum         = '0;
		cmd.op      = spte_pkg::OP_CHAR;
		cmd.ch      = low7;
		if (item.end_flag) begin
			cmd.op          = spte_pkg::OP_MARK;
			cmd.nl_first    = open_q;
			cmd.count       = open_q ? 4'd2 : 4'd1;
			cmd.line_number = line_ext[23:0];
			cmd.page_total  = page_q;
			phase_d         = '0;
			open_d          = 1'b0;
			line_d          = '0;
			page_d          = '0;
		end else if ((item.byte_in & spte_pkg::HIGH_BIT) != 8'd0) begin
			cmd.high = 1'b1;
			if ({1'b0, low7} == spte_pkg::CH_DEL) begin
				cmd.op    = spte_pkg::OP_DEL;
				cmd.count = 4'd5;
			end else if (low7 < 7'h20) begin
				cmd.op    = spte_pkg::OP_CARET;
				cmd.count = 4'd4;
			end else begin
				cmd.count = 4'd3;
			end
			open_d = 1'b1;
		end else if (item.byte_in == spte_pkg::CH_NL) begin
			cmd.op  = spte_pkg::OP_NL;
			cmd.count = 4'd1;
			line_d  = line_q + 1'b1;
			phase_d = '0;
			open_d  = 1'b0;
		end else if (item.byte_in == spte_pkg::CH_CR) begin
			has_cmd = 1'b0;
		end else if (item.byte_in == spte_pkg::CH_FF) begin
			cmd.op          = spte_pkg::OP_MARK;
			cmd.nl_first    = open_q;
			cmd.count       = open_q ? 4'd2 : 4'd1;
			cmd.line_number = line_ext[23:0];
			line_d          = line_closed;
			page_d          = page_q + 16'd1;
			if (open_q) begin
				phase_d = '0;
			end
			open_d = 1'b0;
		end else if (item.byte_in == spte_pkg::CH_TAB) begin
			cmd.op    = spte_pkg::OP_TAB;
			// cap the spaces at eight; the column still lands on the tab stop
			cmd.count = (tab_n > SW'(8)) ? 4'd8 : tab_n[3:0];
			phase_d   = '0;
			open_d    = 1'b1;
		end else if (item.byte_in < 8'h20) begin
			cmd.op    = spte_pkg::OP_CARET;
			cmd.count = 4'd2;
			open_d    = 1'b1;
		end else if (item.byte_in == spte_pkg::CH_DEL) begin
			cmd.op    = spte_pkg::OP_DEL;
			cmd.count = 4'd3;
			open_d    = 1'b1;
		end else begin
			cmd.count = 4'd1;
			open_d    = 1'b1;
		end
		// Advance the column by the characters printed, modulo the tab stop.
		if (!item.end_flag && (cmd.op == spte_pkg::OP_CHAR || cmd.op == spte_pkg::OP_CARET
			|| cmd.op == spte_pkg::OP_DEL)) begin
			sum = SW'(phase_q) + SW'(cmd.count);
			for (int k = 0; k < 3; k++) begin
				if (sum >= SW'(TAB_STOP)) begin
					sum = sum - SW'(TAB_STOP);
				end
			end
			phase_d = sum[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			open_q  <= 1'b0;
			line_q  <= '0;
			page_q  <= '0;
		end else if (accept && has_cmd) begin
			phase_q <= phase_d;
			open_q  <= open_d;
			line_q  <= line_d;
			page_q  <= page_d;
		end
	end

	assign q_wr  = accept && has_cmd;
	assign q_cmd = cmd;

	`ASSERT_IMPLIES(a_cr_dropped, clk, arst_n,
		accept && !item.end_flag && item.byte_in == spte_pkg::CH_CR, !q_wr)
	`ASSERT_NEXT(a_end_clears, clk, arst_n, accept && item.end_flag,
		!open_q && line_q == '0 && page_q == '0)

endmodule

// ===== design/spte_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on spte_pkg for the command type and depth.
`include "assert_macros.svh"

module spte_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  spte_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd,
	output spte_pkg::cmd_t head,
	output logic           q_empty
);

	localparam int DEPTH = spte_pkg::CMD_QDEPTH;
	localparam int PW    = $clog2(DEPTH);

	spte_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [PW:0]    cnt_q;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign head    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, wr, !full || rd)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, rd, !q_empty)

endmodule

// ===== design/spte_back.sv =====
// Back end: expands the head command into one result per cycle while the result
// register is free or popped, and holds the oldest result there. Depends on spte_pkg.
`include "assert_macros.svh"

module spte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  spte_pkg::cmd_t      head,
	input  logic                q_empty,
	output logic                q_rd,
	output logic                empty,
	input  logic                pop,
	output spte_pkg::out_item_t result
);

	logic                idx_q;
	logic [2:0]          pos_q;
	logic                out_valid_q;
	spte_pkg::out_item_t result_q, next_res;
	logic                load;

	assign next_res = spte_pkg::render(head, pos_q);
	assign load     = !q_empty && (!out_valid_q || pop);
	// retire the command with its last result
	assign q_rd     = load && next_res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= next_res.last ? 3'd0 : pos_q + 3'd1;
				idx_q       <= next_res.last;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_res;
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	`ASSERT_IMPLIES(a_pos_in_range, clk, arst_n, !q_empty, ({1'b0, pos_q} < head.count))
	`ASSERT_NEXT(a_last_restarts, clk, arst_n, load && next_res.last, pos_q == 3'd0 && idx_q)

endmodule

// ===== design/spte_core_top.sv =====
// Output stage of the paginator: the command queue feeding the back end.
// Depends on spte_pkg, spte_cmd_fifo and spte_back.
module spte_core_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_wr,
	input  spte_pkg::cmd_t      q_cmd,
	output logic                q_full,
	output logic                empty,
	input  logic                pop,
	output spte_pkg::out_item_t result
);

	spte_pkg::cmd_t head;
	logic           q_empty, q_rd;

	spte_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_cmd  (q_cmd),
		.full    (q_full),
		.rd      (q_rd),
		.head    (head),
		.q_empty (q_empty)
	);

	spte_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== design/spool_text_escape_paginator_core.sv =====
// Text escape paginator: renders print-file bytes in cat -v style, one display
// character or page record per result. A byte expands to 0..8 results; the back
// end emits one result per cycle while the result register is free or popped (a
// carriage return yields no result). Input bytes are taken one per cycle while the
// four-entry command queue has room; the single result register lets the next
// result load in the same cycle the current one is popped.
// Depends on spte_pkg, spte_front, spte_cmd_fifo, spte_back, spte_core_top.
module spool_text_escape_paginator_core #(
	parameter int TAB_STOP  = 8,
	parameter int LINE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  spte_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output spte_pkg::out_item_t result
);

	logic           q_wr;
	spte_pkg::cmd_t q_cmd;

	spte_front #(
		.TAB_STOP  (TAB_STOP),
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (full),
		.q_wr   (q_wr),
		.q_cmd  (q_cmd)
	);

	spte_core_top u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_cmd  (q_cmd),
		.q_full (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== dv/tb_spool_text_escape_paginator_core.sv =====
// Self-checking testbench for spool_text_escape_paginator_core: directed and random print bytes
// against a behavioral renderer, with random idle bursts on both queue sides.
// Depends on spte_pkg and the paginator RTL.
module tb_spool_text_escape_paginator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAB_STOP  = 8;
	localparam int LINE_BITS = 24;
	localparam int MAX_SPACES = 8;
	localparam int RANDOM_REQUESTS = 330;
	localparam int CALM_TAIL = 40;
	localparam int DRAIN_CYCLES = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	spte_pkg::in_item_t  item = '0;
	logic                empty;
	logic                pop = 1'b0;
	spte_pkg::out_item_t result;

	spte_pkg::in_item_t  pending_requests[$];
	spte_pkg::out_item_t expected_glyphs[$];
	spte_pkg::out_item_t want;

	logic        req_taken = 1'b0;
	logic        tail_calm = 1'b0;
	int          src_gap = 0;
	int          src_rate = 0;
	int          snk_gap = 0;
	int          snk_rate = 0;
	int          mismatches = 0;
	int          total_requests = 0;
	int          accepted_count = 0;

	// renderer state
	int          col_phase = 0;
	logic        line_open = 1'b0;
	logic [23:0] line_count = '0;
	logic [15:0] page_count = '0;

	spool_text_escape_paginator_core #(
		.TAB_STOP (TAB_STOP),
		.LINE_BITS(LINE_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic spte_pkg::in_item_t make_request(logic [7:0] b, logic eof);
		spte_pkg::in_item_t r;
		r.byte_in  = b;
		r.end_flag = eof;
		return r;
	endfunction

	task automatic add_record(input logic [7:0] ch, input logic valid, input logic mark,
			input logic [23:0] lines, input logic [15:0] pages);
		spte_pkg::out_item_t r;
		r = '0;
		r.out_char    = ch;
		r.char_valid  = valid;
		r.page_mark   = mark;
		r.line_number = lines;
		r.page_total  = pages;
		expected_glyphs.push_back(r);
	endtask

	task automatic add_glyph(input logic [7:0] ch);
		add_record(ch, 1'b1, 1'b0, '0, '0);
		col_phase = (col_phase + 1) % TAB_STOP;
		line_open = 1'b1;
	endtask

	task automatic add_caret(input logic [6:0] low7);
		add_glyph(spte_pkg::CH_CARET);
		add_glyph({1'b0, low7 + 7'h20});
	endtask

	task automatic add_del();
		add_glyph(spte_pkg::CH_D);
		add_glyph(spte_pkg::CH_E);
		add_glyph(spte_pkg::CH_L);
	endtask

	task automatic count_newline();
		add_record(spte_pkg::CH_NL, 1'b1, 1'b0, '0, '0);
		line_count = line_count + 24'd1;
		col_phase  = 0;
		line_open  = 1'b0;
	endtask

	task automatic close_line();
		if (line_open) begin
			count_newline();
		end
	endtask

	// Expand one accepted request into the display characters and records it causes.
	task automatic render_request(input spte_pkg::in_item_t req);
		int                  queued_at_entry;
		int                  spaces;
		logic [6:0]          low;
		logic [7:0]          b;
		spte_pkg::out_item_t tail;
		queued_at_entry = expected_glyphs.size();
		b = req.byte_in;
		low = b[6:0];
		if (req.end_flag) begin
			close_line();
			add_record(8'h00, 1'b0, 1'b1, line_count, page_count);
			col_phase  = 0;
			line_open  = 1'b0;
			line_count = '0;
			page_count = '0;
		end else if ((b & spte_pkg::HIGH_BIT) != 0) begin
			// high-bit newline, tab and form feed are only rendered
			add_glyph(spte_pkg::CH_M);
			add_glyph(spte_pkg::CH_DASH);
			if ({1'b0, low} == spte_pkg::CH_DEL) begin
				add_del();
			end else if (low < 7'h20) begin
				add_caret(low);
			end else begin
				add_glyph({1'b0, low});
			end
		end else if (b == spte_pkg::CH_NL) begin
			count_newline();
		end else if (b == spte_pkg::CH_CR) begin
			// drop
		end else if (b == spte_pkg::CH_FF) begin
			close_line();
			add_record(8'h00, 1'b0, 1'b1, line_count, '0);
			page_count = page_count + 16'd1;
		end else if (b == spte_pkg::CH_TAB) begin
			spaces = TAB_STOP - (col_phase % TAB_STOP);
			if (spaces > MAX_SPACES) begin
				spaces = MAX_SPACES;
			end
			repeat (spaces) add_record(spte_pkg::CH_SPACE, 1'b1, 1'b0, '0, '0);
			col_phase = 0;
			line_open = 1'b1;
		end else if (b < 8'h20) begin
			add_caret(low);
		end else if (b == spte_pkg::CH_DEL) begin
			add_del();
		end else begin
			add_glyph(b);
		end
		if (expected_glyphs.size() > queued_at_entry) begin
			tail = expected_glyphs.pop_back();
			tail.last = 1'b1;
			expected_glyphs.push_back(tail);
		end
	endtask

	task automatic check_field(input string name, input logic [23:0] exp_v, input logic [23:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Weighted byte mix: mostly printable text, with every kind of special byte.
	function automatic logic [7:0] pick_text_byte();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 52) return 8'($urandom_range(8'h20, 8'h7e));
		if (roll < 60) return spte_pkg::CH_TAB;
		if (roll < 65) return spte_pkg::CH_CR;
		if (roll < 71) return 8'($urandom_range(0, 8'h1f));
		if (roll < 84) return 8'($urandom_range(8'h80, 8'hff));
		if (roll < 87) return spte_pkg::CH_DEL;
		if (roll < 90) return spte_pkg::CH_FF;
		return spte_pkg::CH_NL;
	endfunction

	// request side: hold an offered request until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0) begin
				src_rate <= ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 12);
			end
			if (push && !req_taken) begin
				// hold
			end else if (src_gap != 0) begin
				push <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (!tail_calm && src_rate != 0 && $urandom_range(1, src_rate) == 1) begin
				push <= 1'b0;
				src_gap <= $urandom_range(0, 15);
			end else if (pending_requests.size() != 0) begin
				push <= 1'b1;
				item <= pending_requests.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0) begin
				snk_rate <= ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 12);
			end
			if (snk_gap != 0) begin
				pop <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else if (!tail_calm && snk_rate != 0 && $urandom_range(1, snk_rate) == 1) begin
				pop <= 1'b0;
				snk_gap <= $urandom_range(0, 15);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= push && !full;
			if (pop && !empty) begin
				if (expected_glyphs.size() == 0) begin
					$error("unexpected result: out_char 0x%0h page_mark %0b", result.out_char,
						result.page_mark);
					mismatches++;
				end else begin
					want = expected_glyphs.pop_front();
					check_field("out_char", 24'(want.out_char), 24'(result.out_char));
					check_field("char_valid", 24'(want.char_valid), 24'(result.char_valid));
					check_field("page_mark", 24'(want.page_mark), 24'(result.page_mark));
					check_field("line_number", want.line_number, result.line_number);
					check_field("page_total", 24'(want.page_total), 24'(result.page_total));
					check_field("last", 24'(want.last), 24'(result.last));
				end
			end
			if (push && !full) begin
				render_request(item);
				accepted_count++;
			end
		end
	end

	initial begin
		int   issued;
		int   len;
		int   roll;
		// end marker on an empty file, with a junk byte
		pending_requests.push_back(make_request(8'hff, 1'b1));
		pending_requests.push_back(make_request(8'h41, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_TAB, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_TAB, 1'b0));
		pending_requests.push_back(make_request(8'h00, 1'b0));
		pending_requests.push_back(make_request(8'h1f, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_DEL, 1'b0));
		pending_requests.push_back(make_request(8'h20, 1'b0));
		pending_requests.push_back(make_request(8'h7e, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_CR, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_NL, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_FF, 1'b0));
		pending_requests.push_back(make_request(8'h80, 1'b0));
		pending_requests.push_back(make_request(8'hff, 1'b0));
		pending_requests.push_back(make_request(8'h9f, 1'b0));
		pending_requests.push_back(make_request(8'h8a, 1'b0));
		pending_requests.push_back(make_request(8'h89, 1'b0));
		pending_requests.push_back(make_request(8'h8c, 1'b0));
		pending_requests.push_back(make_request(8'h8d, 1'b0));
		pending_requests.push_back(make_request(8'ha0, 1'b0));
		pending_requests.push_back(make_request(spte_pkg::CH_FF, 1'b0));
		pending_requests.push_back(make_request(8'h78, 1'b0));
		pending_requests.push_back(make_request(8'h00, 1'b1));
		pending_requests.push_back(make_request(spte_pkg::CH_NL, 1'b0));
		pending_requests.push_back(make_request(8'h5a, 1'b1));

		// random files made of lines of mixed text
		issued = 0;
		while (issued < RANDOM_REQUESTS) begin
			len = $urandom_range(0, 12);
			repeat (len) begin
				pending_requests.push_back(make_request(pick_text_byte(), 1'b0));
				issued++;
			end
			roll = $urandom_range(0, 19);
			if (roll < 2) begin
				pending_requests.push_back(make_request(8'($urandom_range(0, 255)), 1'b1));
			end else if (roll < 4) begin
				pending_requests.push_back(make_request(spte_pkg::CH_FF, 1'b0));
			end else if (roll < 5) begin
				continue;
			end else begin
				pending_requests.push_back(make_request(spte_pkg::CH_NL, 1'b0));
			end
			issued++;
		end
		total_requests = pending_requests.size();

		repeat (10) @(negedge clk);
		#1 arst_n = 1'b1;

		while (pending_requests.size() >= CALM_TAIL) @(negedge clk);
		tail_calm = 1'b1;
		while (accepted_count != total_requests) @(negedge clk);
		while (expected_glyphs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_glyphs.size() != 0) begin
			$error("result count: expected %0d more, got 0", expected_glyphs.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
